### hdl/ray_annulus_intersection_top_assert.svh
// Assertion macros for the ray and annulus intersection block.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef RAY_ANNULUS_INTERSECTION_TOP_ASSERT_SVH
`define RAY_ANNULUS_INTERSECTION_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RAI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rai: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RAI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rai: next-cycle check failed");

`endif

### hdl/rai_pkg.sv
// Shared widths, register codes, types and helper functions for the
// ray and annulus intersection block. No dependencies.
`timescale 1ns / 1ps

package rai_pkg;

    localparam int CW      = 32;             // coordinate width
    localparam int FB      = 16;             // fraction bits
    localparam int UW      = CW + FB;        // ray parameter width
    localparam int PW      = UW + CW;        // full product width
    localparam int CAP_LOG = 62;             // products above 2**CAP_LOG are capped
    localparam int SQ_LOG  = 32;             // squares of values at or above 2**SQ_LOG saturate
    localparam int WW      = CAP_LOG + 3;    // plane coordinate sum width
    localparam int XW      = WW - FB;        // plane coordinate width after the shift
    localparam int DW      = 64;             // squared distance width
    localparam int IR_W    = 31;             // radius register width
    localparam int EPS_W   = 16;             // epsilon register width
    localparam int PRW     = EPS_W + CW;     // epsilon times |dz| width
    localparam int CMPW    = (UW > PRW) ? UW : PRW;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 32;

    localparam logic [IR_W-1:0]  INNER_RESET = '0;
    localparam logic [IR_W-1:0]  OUTER_RESET = IR_W'(64'd1 << FB);
    localparam logic [EPS_W-1:0] EPS_RESET   = EPS_W'(1);
    localparam logic [PW-1:0]    PROD_CAP    = PW'(1) << CAP_LOG;

    typedef enum logic [CFG_IW-1:0] {
        REG_INNER = 2'd0,
        REG_OUTER = 2'd1,
        REG_EPS   = 2'd2
    } rai_reg_t;

    // One divider step travels with everything the later stages need.
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [UW-1:0] num;
        logic [CW-1:0] dvs;
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [CW-1:0] adx;
        logic [CW-1:0] ady;
        logic          dxn;
        logic          dyn;
        logic          normal_up;
        logic          miss;
    } rai_div_t;

    typedef struct packed {
        logic          hit;
        logic [CW-1:0] hit_x;
        logic [CW-1:0] hit_y;
        logic [DW-1:0] dist_sq;
        logic          normal_up;
    } rai_res_t;

    function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
        return v[CW-1] ? CW'(~v + 1'b1) : v;
    endfunction

    // Restoring division: one quotient bit; the quotient shifts into num.
    function automatic rai_div_t div_step(input rai_div_t s);
        rai_div_t     t;
        logic [CW:0]  trial;
        logic         ge;
        t     = s;
        trial = {s.rem, s.num[UW-1]};
        ge    = (trial >= {1'b0, s.dvs});
        t.rem = ge ? CW'(trial - {1'b0, s.dvs}) : trial[CW-1:0];
        t.num = {s.num[UW-2:0], ge};
        return t;
    endfunction

endpackage

### hdl/rai_ifs.sv
// Handshake channel interfaces for rays, results and register writes.
// Depends on rai_pkg.
`timescale 1ns / 1ps

interface rai_ray_if;
    logic                           valid;
    logic                           ready;
    logic signed [rai_pkg::CW-1:0]  origin_x;
    logic signed [rai_pkg::CW-1:0]  origin_y;
    logic signed [rai_pkg::CW-1:0]  origin_z;
    logic signed [rai_pkg::CW-1:0]  dir_x;
    logic signed [rai_pkg::CW-1:0]  dir_y;
    logic signed [rai_pkg::CW-1:0]  dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rai_res_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic signed [rai_pkg::CW-1:0]  hit_x;
    logic signed [rai_pkg::CW-1:0]  hit_y;
    logic [rai_pkg::DW-1:0]         dist_sq;
    logic                           normal_up;
    modport source (output valid, hit, hit_x, hit_y, dist_sq, normal_up, input ready);
    modport sink (input valid, hit, hit_x, hit_y, dist_sq, normal_up, output ready);
endinterface

interface rai_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rai_pkg::CFG_IW-1:0]     index;
    logic [rai_pkg::CFG_DW-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/ray_annulus_intersection_top.sv
// Ray against flat annulus in z = 0; depends on rai_pkg, rai_ifs and the assertion header.
// The one-bit-per-stage divider (48 stages) sits between stages of setup, multiply, add and
// compare. Throughput is one ray per cycle while the skid stage is empty; an output register
// and a skid stage keep the input open while one result waits. Reset clears all valid bits
// and loads the registers with inner 0, outer 1.0 and epsilon one LSB.
`timescale 1ns / 1ps
`include "ray_annulus_intersection_top_assert.svh"

module ray_annulus_intersection_top (
    input  logic        clk,
    input  logic        rst_n,
    rai_ray_if.sink     ray,
    rai_res_if.source   result,
    rai_cfg_if.sink     cfg
);

    localparam int CW = rai_pkg::CW;
    localparam int FB = rai_pkg::FB;
    localparam int UW = rai_pkg::UW;
    localparam int PW = rai_pkg::PW;
    localparam int WW = rai_pkg::WW;
    localparam int XW = rai_pkg::XW;
    localparam int DW = rai_pkg::DW;

    // ---------------- configuration ----------------
    logic [rai_pkg::IR_W-1:0]   inner_reg;
    logic [rai_pkg::IR_W-1:0]   outer_reg;
    logic [rai_pkg::EPS_W-1:0]  eps_reg;
    logic [2*rai_pkg::IR_W-1:0] inner_sq_reg;
    logic [2*rai_pkg::IR_W-1:0] outer_sq_reg;
    logic [DW-1:0]              bound_reg;
    logic [DW-1:0]              eps_sq;

    assign cfg.ready = 1'b1;
    assign eps_sq    = DW'(eps_reg) << FB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= rai_pkg::INNER_RESET;
            outer_reg <= rai_pkg::OUTER_RESET;
            eps_reg   <= rai_pkg::EPS_RESET;
        end
        else if (cfg.valid)
        begin
            case (rai_pkg::rai_reg_t'(cfg.index))
                rai_pkg::REG_INNER: inner_reg <= cfg.data[rai_pkg::IR_W-1:0];
                rai_pkg::REG_OUTER: outer_reg <= cfg.data[rai_pkg::IR_W-1:0];
                rai_pkg::REG_EPS:   eps_reg   <= cfg.data[rai_pkg::EPS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Derived bounds are registered: the squares from the radius registers, then the outer bound.
    always_ff @(posedge clk)
    begin
        inner_sq_reg <= (2*rai_pkg::IR_W)'(inner_reg) * (2*rai_pkg::IR_W)'(inner_reg);
        outer_sq_reg <= (2*rai_pkg::IR_W)'(outer_reg) * (2*rai_pkg::IR_W)'(outer_reg);
        bound_reg    <= DW'(outer_sq_reg) + eps_sq;
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic push;

    assign en        = !skid_valid_reg;
    assign ray.ready = en;

    // ---------------- stage A: magnitudes and signs ----------------
    logic          a_valid_reg;
    logic [CW-1:0] a_ox_reg, a_oy_reg, a_adx_reg, a_ady_reg, a_adz_reg, a_aoz_reg;
    logic          a_dxn_reg, a_dyn_reg, a_ozn_reg, a_dzn_reg, a_ozz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ox_reg  <= ray.origin_x;
            a_oy_reg  <= ray.origin_y;
            a_adx_reg <= rai_pkg::mag(ray.dir_x);
            a_ady_reg <= rai_pkg::mag(ray.dir_y);
            a_adz_reg <= rai_pkg::mag(ray.dir_z);
            a_aoz_reg <= rai_pkg::mag(ray.origin_z);
            a_dxn_reg <= ray.dir_x[CW-1];
            a_dyn_reg <= ray.dir_y[CW-1];
            a_ozn_reg <= ray.origin_z[CW-1];
            a_dzn_reg <= ray.dir_z[CW-1];
            a_ozz_reg <= (ray.origin_z == '0);
        end
    end

    // ---------------- stage B: parallel and side tests ----------------
    logic                    b_valid_reg;
    logic [rai_pkg::PRW-1:0] b_prod_reg;
    logic [CW-1:0]           b_ox_reg, b_oy_reg, b_adx_reg, b_ady_reg, b_adz_reg, b_aoz_reg;
    logic                    b_dxn_reg, b_dyn_reg, b_up_reg, b_miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_prod_reg <= rai_pkg::PRW'(a_adz_reg) * rai_pkg::PRW'(eps_reg);
            b_miss_reg <= (a_adz_reg <= CW'(eps_reg)) || a_ozz_reg || (a_ozn_reg == a_dzn_reg);
            b_ox_reg   <= a_ox_reg;
            b_oy_reg   <= a_oy_reg;
            b_adx_reg  <= a_adx_reg;
            b_ady_reg  <= a_ady_reg;
            b_adz_reg  <= a_adz_reg;
            b_aoz_reg  <= a_aoz_reg;
            b_dxn_reg  <= a_dxn_reg;
            b_dyn_reg  <= a_dyn_reg;
            b_up_reg   <= !a_ozn_reg;
        end
    end

    // ---------------- divider: u = |oz| * 2^FB / |dz| ----------------
    rai_pkg::rai_div_t dv_reg [0:UW];
    logic              dv_valid_reg [0:UW];
    logic [UW-1:0]     dividend;

    assign dividend = {b_aoz_reg, {FB{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].rem       <= '0;
            dv_reg[0].num       <= dividend;
            dv_reg[0].dvs       <= b_adz_reg;
            dv_reg[0].ox        <= b_ox_reg;
            dv_reg[0].oy        <= b_oy_reg;
            dv_reg[0].adx       <= b_adx_reg;
            dv_reg[0].ady       <= b_ady_reg;
            dv_reg[0].dxn       <= b_dxn_reg;
            dv_reg[0].dyn       <= b_dyn_reg;
            dv_reg[0].normal_up <= b_up_reg;
            // Behind test: u must be above epsilon.
            dv_reg[0].miss      <= b_miss_reg ||
                (rai_pkg::CMPW'(dividend) <= rai_pkg::CMPW'(b_prod_reg));
            for (int k = 1; k <= UW; k++)
            begin
                dv_reg[k] <= rai_pkg::div_step(dv_reg[k-1]);
            end
        end
    end

    // ---------------- P1: partial products of u times |d| ----------------
    rai_pkg::rai_div_t dq;
    logic [UW-1:0]     u;
    logic              p1_valid_reg;
    logic [2*CW-1:0]   p1_lx_reg, p1_ly_reg, p1_lz_reg;
    logic [FB+CW-1:0]  p1_hx_reg, p1_hy_reg, p1_hz_reg;
    logic [CW-1:0]     p1_ox_reg, p1_oy_reg;
    logic              p1_dxn_reg, p1_dyn_reg, p1_up_reg, p1_miss_reg;

    assign dq = dv_reg[UW];
    assign u  = dq.num;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_lx_reg   <= (2*CW)'(u[CW-1:0]) * (2*CW)'(dq.adx);
            p1_ly_reg   <= (2*CW)'(u[CW-1:0]) * (2*CW)'(dq.ady);
            p1_lz_reg   <= (2*CW)'(u[CW-1:0]) * (2*CW)'(dq.dvs);
            p1_hx_reg   <= (FB+CW)'(u[UW-1:CW]) * (FB+CW)'(dq.adx);
            p1_hy_reg   <= (FB+CW)'(u[UW-1:CW]) * (FB+CW)'(dq.ady);
            p1_hz_reg   <= (FB+CW)'(u[UW-1:CW]) * (FB+CW)'(dq.dvs);
            p1_ox_reg   <= dq.ox;
            p1_oy_reg   <= dq.oy;
            p1_dxn_reg  <= dq.dxn;
            p1_dyn_reg  <= dq.dyn;
            p1_up_reg   <= dq.normal_up;
            p1_miss_reg <= dq.miss;
        end
    end

    // ---------------- P2: full products ----------------
    logic          p2_valid_reg;
    logic [PW-1:0] p2_px_reg, p2_py_reg, p2_pz_reg;
    logic [CW-1:0] p2_ox_reg, p2_oy_reg;
    logic          p2_dxn_reg, p2_dyn_reg, p2_up_reg, p2_miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_px_reg   <= PW'(p1_lx_reg) + (PW'(p1_hx_reg) << CW);
            p2_py_reg   <= PW'(p1_ly_reg) + (PW'(p1_hy_reg) << CW);
            p2_pz_reg   <= PW'(p1_lz_reg) + (PW'(p1_hz_reg) << CW);
            p2_ox_reg   <= p1_ox_reg;
            p2_oy_reg   <= p1_oy_reg;
            p2_dxn_reg  <= p1_dxn_reg;
            p2_dyn_reg  <= p1_dyn_reg;
            p2_up_reg   <= p1_up_reg;
            p2_miss_reg <= p1_miss_reg;
        end
    end

    // ---------------- P3: plane coordinates and displacement terms ----------------
    logic signed [WW-1:0] ox_w, oy_w, wx, wy;
    logic [XW-1:0]        xs, ys;
    logic                 capx, capy, capz;
    logic                 p3_valid_reg;
    logic [CW-1:0]        p3_x_reg, p3_y_reg, p3_qx_reg, p3_qy_reg, p3_qz_reg;
    logic                 p3_big_reg, p3_satx_reg, p3_saty_reg, p3_satz_reg;
    logic                 p3_up_reg, p3_miss_reg;

    always_comb
    begin
        capx = (p2_px_reg > rai_pkg::PROD_CAP);
        capy = (p2_py_reg > rai_pkg::PROD_CAP);
        capz = (p2_pz_reg > rai_pkg::PROD_CAP);
        ox_w = {{(WW-CW){p2_ox_reg[CW-1]}}, p2_ox_reg} <<< FB;
        oy_w = {{(WW-CW){p2_oy_reg[CW-1]}}, p2_oy_reg} <<< FB;
        wx   = p2_dxn_reg ? ox_w - WW'(p2_px_reg[rai_pkg::CAP_LOG:0])
                          : ox_w + WW'(p2_px_reg[rai_pkg::CAP_LOG:0]);
        wy   = p2_dyn_reg ? oy_w - WW'(p2_py_reg[rai_pkg::CAP_LOG:0])
                          : oy_w + WW'(p2_py_reg[rai_pkg::CAP_LOG:0]);
        // Dropping the fraction of a two's complement value floors it.
        xs   = wx[WW-1:FB];
        ys   = wy[WW-1:FB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_x_reg    <= xs[CW-1:0];
            p3_y_reg    <= ys[CW-1:0];
            // A coordinate outside the signed range squares past any radius bound.
            p3_big_reg  <= capx || capy ||
                           !((&xs[XW-1:CW-1]) || !(|xs[XW-1:CW-1])) ||
                           !((&ys[XW-1:CW-1]) || !(|ys[XW-1:CW-1]));
            p3_qx_reg   <= p2_px_reg[FB+rai_pkg::SQ_LOG-1:FB];
            p3_qy_reg   <= p2_py_reg[FB+rai_pkg::SQ_LOG-1:FB];
            p3_qz_reg   <= p2_pz_reg[FB+rai_pkg::SQ_LOG-1:FB];
            p3_satx_reg <= capx || (|p2_px_reg[rai_pkg::CAP_LOG:FB+rai_pkg::SQ_LOG]);
            p3_saty_reg <= capy || (|p2_py_reg[rai_pkg::CAP_LOG:FB+rai_pkg::SQ_LOG]);
            p3_satz_reg <= capz || (|p2_pz_reg[rai_pkg::CAP_LOG:FB+rai_pkg::SQ_LOG]);
            p3_up_reg   <= p2_up_reg;
            p3_miss_reg <= p2_miss_reg;
        end
    end

    // ---------------- P4: squares ----------------
    logic                 p4_valid_reg;
    logic signed [DW-1:0] x2_s, y2_s;
    logic [DW-1:0]        p4_x2_reg, p4_y2_reg, p4_dx_reg, p4_dy_reg, p4_dz_reg;
    logic [CW-1:0]        p4_x_reg, p4_y_reg;
    logic                 p4_satx_reg, p4_saty_reg, p4_satz_reg, p4_up_reg, p4_miss_reg;

    assign x2_s = DW'($signed(p3_x_reg)) * DW'($signed(p3_x_reg));
    assign y2_s = DW'($signed(p3_y_reg)) * DW'($signed(p3_y_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_x2_reg   <= x2_s;
            p4_y2_reg   <= y2_s;
            p4_dx_reg   <= DW'(p3_qx_reg) * DW'(p3_qx_reg);
            p4_dy_reg   <= DW'(p3_qy_reg) * DW'(p3_qy_reg);
            p4_dz_reg   <= DW'(p3_qz_reg) * DW'(p3_qz_reg);
            p4_x_reg    <= p3_x_reg;
            p4_y_reg    <= p3_y_reg;
            p4_satx_reg <= p3_satx_reg;
            p4_saty_reg <= p3_saty_reg;
            p4_satz_reg <= p3_satz_reg;
            p4_up_reg   <= p3_up_reg;
            p4_miss_reg <= p3_miss_reg || p3_big_reg;
        end
    end

    // ---------------- P5: radius sum and first distance sum ----------------
    logic          p5_valid_reg;
    logic [DW:0]   sum01;
    logic [DW-1:0] p5_m_reg, p5_d01_reg, p5_dz_reg;
    logic [CW-1:0] p5_x_reg, p5_y_reg;
    logic          p5_sat01_reg, p5_satz_reg, p5_up_reg, p5_miss_reg;

    assign sum01 = (DW+1)'(p4_dx_reg) + (DW+1)'(p4_dy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_m_reg     <= p4_x2_reg + p4_y2_reg;
            p5_d01_reg   <= sum01[DW-1:0];
            p5_sat01_reg <= p4_satx_reg || p4_saty_reg || sum01[DW];
            p5_dz_reg    <= p4_dz_reg;
            p5_satz_reg  <= p4_satz_reg;
            p5_x_reg     <= p4_x_reg;
            p5_y_reg     <= p4_y_reg;
            p5_up_reg    <= p4_up_reg;
            p5_miss_reg  <= p4_miss_reg;
        end
    end

    // ---------------- P6: band test and final distance ----------------
    logic              p6_valid_reg;
    logic [DW:0]       sum_d;
    logic [DW:0]       m_eps;
    logic              miss6;
    rai_pkg::rai_res_t res_next;
    rai_pkg::rai_res_t p6_res_reg;

    always_comb
    begin
        sum_d = (DW+1)'(p5_d01_reg) + (DW+1)'(p5_dz_reg);
        m_eps = (DW+1)'(p5_m_reg) + (DW+1)'(eps_sq);
        miss6 = p5_miss_reg || (p5_m_reg > bound_reg) ||
                (m_eps < (DW+1)'(inner_sq_reg));
        res_next = '0;
        if (!miss6)
        begin
            res_next.hit       = 1'b1;
            res_next.hit_x     = p5_x_reg;
            res_next.hit_y     = p5_y_reg;
            res_next.dist_sq   = (p5_sat01_reg || p5_satz_reg || sum_d[DW]) ?
                                 '1 : sum_d[DW-1:0];
            res_next.normal_up = p5_up_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p6_res_reg <= res_next;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            for (int k = 0; k <= UW; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg     <= ray.valid;
            b_valid_reg     <= a_valid_reg;
            dv_valid_reg[0] <= b_valid_reg;
            for (int k = 1; k <= UW; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            p1_valid_reg <= dv_valid_reg[UW];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
        end
    end

    // ---------------- output register and skid stage ----------------
    rai_pkg::rai_res_t out_reg;
    rai_pkg::rai_res_t skid_reg;

    assign push = en && p6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : p6_res_reg;
        end
        else if (push)
        begin
            skid_reg <= p6_res_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.hit       = out_reg.hit;
    assign result.hit_x     = out_reg.hit_x;
    assign result.hit_y     = out_reg.hit_y;
    assign result.dist_sq   = out_reg.dist_sq;
    assign result.normal_up = out_reg.normal_up;

    // ---------------- assertions ----------------
    `RAI_ASSERT_NOW(a_miss_zero, result.valid && !result.hit, result.hit_x == '0 && result.hit_y == '0 && result.dist_sq == '0 && !result.normal_up)
    `RAI_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `RAI_ASSERT_NEXT(a_skid_catches, out_valid_reg && !result.ready && push, skid_valid_reg)

endmodule
